// File: rtl/mpqs_pkg.sv
// Shared types and constants of the minimum-priority queue scan core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package mpqs_pkg;

  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;
  localparam int DEPTH_DEF = 16;

  // Operation kinds on the input channel
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [1:0] STAT_DEQUEUED = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // input transfer taken this cycle
    logic scan_rd;    // issue one read of the minimum search
    logic best_take;  // search finished: latch winner, set up the shift
    logic shift_rd;   // issue one read of the close-up shift
    logic dec_count;  // one entry has left the store
    logic out_load;   // move the result into the output register
  } mpqs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;      // no stored entries
    logic rd_last;    // read pointer sits on the newest stored entry
    logic no_shift;   // winner is the newest entry, nothing to close up
    logic out_free;   // output register can take a result this cycle
  } mpqs_stat_t;

endpackage

// File: rtl/mpqs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mpqs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mpqs_ctrl.sv
// Sequencing controller of the minimum-priority queue scan core.
// Depends on mpqs_pkg for the command and status structs and the kind codes.
`timescale 1ns / 1ps

module mpqs_ctrl
  import mpqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  mpqs_stat_t stat,
  output mpqs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_SCAN_END  = 3'd2;
  localparam logic [2:0] S_TAKE      = 3'd3;
  localparam logic [2:0] S_SHIFT     = 3'd4;
  localparam logic [2:0] S_SHIFT_END = 3'd5;
  localparam logic [2:0] S_RESP      = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == KIND_DEQ && !stat.empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      // last compare lands in the best registers
      S_SCAN_END: begin
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.best_take = 1'b1;
        if (stat.no_shift) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_SHIFT_END;
        end
      end
      // final shifted write completes here
      S_SHIFT_END: begin
        cmd.dec_count = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/mpqs_dpath.sv
// Datapath of the minimum-priority queue scan core: entry store, scan and
// shift pointers, best-entry registers and the output register.
// Depends on mpqs_pkg and mpqs_ram.
`timescale 1ns / 1ps

module mpqs_dpath
  import mpqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mpqs_cmd_t         cmd,
  output mpqs_stat_t        stat,
  input  logic              in_kind,
  input  logic [DATA_W-1:0] in_data,
  input  logic [DATA_W-1:0] in_prio,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [DATA_W-1:0] out_data,
  output logic [DATA_W-1:0] out_prio,
  output logic [OCC_W-1:0]  out_occ
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = 2 * DATA_W;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     rd_ptr_r;
  logic              cmp_vld_r;
  logic [AW-1:0]     cmp_idx_r;
  logic [AW-1:0]     best_idx_r;
  logic [DATA_W-1:0] best_data_r;
  logic [DATA_W-1:0] best_prio_r;
  logic              wr_pend_r;
  logic [AW-1:0]     wr_addr_r;
  logic [1:0]        res_status_r;
  logic [DATA_W-1:0] res_data_r;
  logic [DATA_W-1:0] res_prio_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] out_prio_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              full;
  logic              enq_wr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic [RW-1:0]     ram_rdata;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] rd_prio;
  logic              take_new;
  logic [CW-1:0]     after_best;
  logic [CW+OCC_W-1:0] occ_ext;

  assign full    = (count_r == CW'(DEPTH));
  assign enq_wr  = cmd.accept && (in_kind == KIND_ENQ) && !full;
  assign rd_data = ram_rdata[DATA_W-1:0];
  assign rd_prio = ram_rdata[RW-1:DATA_W];

  // Write port: shift write-back has the port, otherwise the new entry
  assign ram_we    = wr_pend_r || enq_wr;
  assign ram_waddr = wr_pend_r ? wr_addr_r : count_r[AW-1:0];
  assign ram_wdata = wr_pend_r ? ram_rdata : {in_prio, in_data};

  mpqs_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_ptr_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Signed compare; on a tie the higher slot (newer entry) wins
  assign take_new   = (cmp_idx_r == '0) || ($signed(rd_prio) <= $signed(best_prio_r));
  assign after_best = CW'(best_idx_r) + CW'(1);

  assign stat.empty    = (count_r == '0);
  assign stat.rd_last  = (rd_ptr_r == count_r - CW'(1));
  assign stat.no_shift = (after_best == count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign occ_ext = (CW + OCC_W)'(count_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (enq_wr) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
      cmp_vld_r <= cmd.scan_rd;
      wr_pend_r <= cmd.shift_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pointers, search registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ptr_r <= '0;
    end else if (cmd.best_take) begin
      rd_ptr_r <= after_best;
    end else if (cmd.scan_rd || cmd.shift_rd) begin
      rd_ptr_r <= rd_ptr_r + CW'(1);
    end
    cmp_idx_r <= rd_ptr_r[AW-1:0];
    wr_addr_r <= rd_ptr_r[AW-1:0] - AW'(1);

    if (cmp_vld_r && take_new) begin
      best_idx_r  <= cmp_idx_r;
      best_data_r <= rd_data;
      best_prio_r <= rd_prio;
    end

    // result: status chosen at the transfer, winner latched after the search
    if (cmd.accept) begin
      res_data_r <= '0;
      res_prio_r <= '0;
      if (in_kind == KIND_ENQ) begin
        res_status_r <= full ? STAT_FULL : STAT_ENQUEUED;
      end else begin
        res_status_r <= stat.empty ? STAT_EMPTY : STAT_DEQUEUED;
      end
    end else if (cmd.best_take) begin
      res_data_r <= best_data_r;
      res_prio_r <= best_prio_r;
    end

    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_prio_r   <= res_prio_r;
      out_occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_prio   = out_prio_r;
  assign out_occ    = out_occ_r;

endmodule

// File: rtl/min_priority_queue_scan_core.sv
// Minimum-priority queue scan core: bounded store of (data, priority) pairs.
// Usage:
//   Input transfer: in_tuser is the kind (0 enqueue, 1 dequeue), in_tdata
//   carries data and priority. Every input transfer gives one result transfer:
//   out_tuser is the status (0 enqueued, 1 dequeued, 2 empty, 3 full and
//   dropped), out_tdata the removed entry (zero unless dequeued) and the
//   occupancy after the operation.
//   An enqueue, a dropped enqueue or a dequeue on an empty store goes from
//   the input transfer straight to its result. A dequeue with N entries
//   stored and the winner in slot B (0 oldest) first walks all N entries
//   for the minimum, one store read per cycle, then, unless B is N - 1,
//   closes the gap behind the winner with one read-write per cycle before
//   its result. The single store read port sets both rates.
//   One item is worked on at a time; in_tready is high only while idle.
//   A result waits in the output register while out_tready is low; the next
//   item is still taken and held complete until the register frees.
//   Ties go to the most recently enqueued entry. Priorities compare signed.
//   Reset (rst_n low, synchronous) empties the store; no clearing pass.
// Depends on mpqs_pkg, mpqs_ctrl, mpqs_dpath and mpqs_ram.
`timescale 1ns / 1ps

module min_priority_queue_scan_core
  import mpqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] data_value, [63:32] priority_value
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] out_data, [63:32] out_priority,
                                  // [68:64] occupancy, [71:69] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  mpqs_cmd_t         cmd;
  mpqs_stat_t        stat;
  logic [DATA_W-1:0] res_data;
  logic [DATA_W-1:0] res_prio;
  logic [OCC_W-1:0]  res_occ;

  mpqs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_kind (in_tuser),
    .in_ready(in_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  mpqs_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (in_tuser),
    .in_data   (in_tdata[31:0]),
    .in_prio   (in_tdata[63:32]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_status(out_tuser),
    .out_data  (res_data),
    .out_prio  (res_prio),
    .out_occ   (res_occ)
  );

  assign out_tdata = {3'b000, res_occ, res_prio, res_data};

endmodule
